FILE: rtl/ufsm_pkg.sv
`default_nettype none

package ufsm_pkg;

    localparam int unsigned NODES_DEF = 1024;
    localparam int unsigned MAX_NODES = 1024;
    localparam int unsigned IDX_W     = 10;
    localparam int unsigned CNT_W     = 11;

    localparam logic REQ_UNITE = 1'b0;
    localparam logic REQ_FIND  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_HALVE,
        ST_LINK,
        ST_GROW
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/ufsm_ram.sv
`default_nettype none

module ufsm_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10,
    parameter int unsigned DW    = 21
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/union_find_set_merger_unit.sv
// Timing: a request with a bad index answers in the cycle after start; a find keeps busy
// high while it walks the path from node_a to its root, with done rising as busy drops;
// a unite runs two such walks, then the link and grow states when it links roots.
// One request at a time: busy stays high until done. Every table access goes through
// the single-port-write node memory. Reset and every num_nodes write start a clearing
// pass over min(NODES,1024) entries with busy high. The receiver cannot stall.
`default_nettype none

module union_find_set_merger_unit #(
    parameter int unsigned NODES = ufsm_pkg::NODES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [ufsm_pkg::CNT_W-1:0]  cfg_wdata,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        req_type,
    input  wire logic [ufsm_pkg::IDX_W-1:0]  node_a,
    input  wire logic [ufsm_pkg::IDX_W-1:0]  node_b,
    output logic                             done,
    output logic                             merged,
    output logic      [ufsm_pkg::IDX_W-1:0]  root_index,
    output logic      [ufsm_pkg::CNT_W-1:0]  root_set_size,
    output logic      [ufsm_pkg::CNT_W-1:0]  components_left,
    output logic                             single_set,
    output logic                             index_error
);

    import ufsm_pkg::*;

    localparam int unsigned DEPTH = (NODES < MAX_NODES) ? NODES : MAX_NODES;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned SW    = $clog2(DEPTH + 1);
    localparam int unsigned DW    = SW + AW;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [AW-1:0]    LAST_IDX = AW'(DEPTH - 1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] num_nodes_reg, num_nodes_next;
    logic [AW-1:0]    merge_total_reg, merge_total_next;
    logic [AW-1:0]    clr_idx_reg, clr_idx_next;
    logic             req_reg, req_next;
    logic [AW-1:0]    node_b_reg, node_b_next;
    logic [AW-1:0]    cur_reg, cur_next;
    logic [SW-1:0]    cur_size_reg, cur_size_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic             phase_reg, phase_next;
    logic [AW-1:0]    root_a_reg, root_a_next;
    logic [SW-1:0]    size_a_reg, size_a_next;
    logic [AW-1:0]    root_b_reg, root_b_next;
    logic [SW-1:0]    size_b_reg, size_b_next;

    logic             done_reg, done_next;
    logic             merged_reg, merged_next;
    logic [AW-1:0]    root_reg, root_next;
    logic [SW-1:0]    size_reg, size_next;
    logic             error_reg, error_next;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [DW-1:0]    mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [DW-1:0]    mem_rdata;
    logic [AW-1:0]    rd_par;
    logic [SW-1:0]    rd_size;

    logic [CNT_W-1:0] n_use;
    logic [CNT_W-1:0] mt_ext;
    logic [CNT_W-1:0] left;
    logic             accept;
    logic             req_bad;
    logic             found;
    logic [AW-1:0]    found_idx;
    logic             last_walk;
    logic             same_root;
    logic             a_bigger;
    logic [AW-1:0]    big_root;
    logic [AW-1:0]    small_root;
    logic [SW-1:0]    small_size;
    logic [SW:0]      sum_wide;
    logic [SW-1:0]    sum_size;

    ufsm_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_par  = mem_rdata[AW-1:0];
    assign rd_size = mem_rdata[DW-1:AW];

    // clamp the element count to [1, DEPTH]
    always_comb
    begin
        priority if (num_nodes_reg == '0)
        begin
            n_use = CNT_W'(1);
        end
        else if (num_nodes_reg > DEPTH_C)
        begin
            n_use = DEPTH_C;
        end
        else
        begin
            n_use = num_nodes_reg;
        end
    end

    assign mt_ext = CNT_W'(merge_total_reg);
    assign left   = (mt_ext < n_use) ? (n_use - mt_ext) : '0;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign req_bad = ({1'b0, node_a} >= n_use) ||
                     ((req_type == REQ_UNITE) && ({1'b0, node_b} >= n_use));

    // a root shows up either at the node itself or at its parent during halving
    assign found     = ((state_reg == ST_CHECK) && (rd_par == cur_reg)) ||
                       ((state_reg == ST_HALVE) && (rd_par == ptr_reg));
    assign found_idx = (state_reg == ST_CHECK) ? cur_reg : ptr_reg;
    assign last_walk = phase_reg || (req_reg == REQ_FIND);
    assign same_root = (found_idx == root_a_reg);

    assign a_bigger   = !(size_a_reg < size_b_reg);
    assign big_root   = a_bigger ? root_a_reg : root_b_reg;
    assign small_root = a_bigger ? root_b_reg : root_a_reg;
    assign small_size = a_bigger ? size_b_reg : size_a_reg;
    assign sum_wide   = {1'b0, size_a_reg} + {1'b0, size_b_reg};
    assign sum_size   = sum_wide[SW-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && !req_bad)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK, ST_HALVE:
            begin
                if (found)
                begin
                    if (!last_walk)
                    begin
                        state_next = ST_CHECK;
                    end
                    else if ((req_reg == REQ_FIND) || same_root)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_LINK;
                    end
                end
                else
                begin
                    state_next = (state_reg == ST_CHECK) ? ST_HALVE : ST_CHECK;
                end
            end
            ST_LINK:
            begin
                state_next = ST_GROW;
            end
            ST_GROW:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cfg_we)
        begin
            state_next = ST_CLEAR;
        end
    end

    always_comb
    begin
        num_nodes_next   = num_nodes_reg;
        merge_total_next = merge_total_reg;
        clr_idx_next     = clr_idx_reg;
        req_next         = req_reg;
        node_b_next      = node_b_reg;
        cur_next         = cur_reg;
        cur_size_next    = cur_size_reg;
        ptr_next         = ptr_reg;
        phase_next       = phase_reg;
        root_a_next      = root_a_reg;
        size_a_next      = size_a_reg;
        root_b_next      = root_b_reg;
        size_b_next      = size_b_reg;
        done_next        = 1'b0;
        merged_next      = merged_reg;
        root_next        = root_reg;
        size_next        = size_reg;
        error_next       = error_reg;
        mem_we           = 1'b0;
        mem_waddr        = cur_reg;
        mem_wdata        = {cur_size_reg, rd_par};
        mem_raddr        = cur_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = {SW'(1), clr_idx_reg};
                clr_idx_next = clr_idx_reg + AW'(1);
            end
            ST_IDLE:
            begin
                mem_raddr = node_a[AW-1:0];
                if (accept)
                begin
                    if (req_bad)
                    begin
                        done_next   = 1'b1;
                        error_next  = 1'b1;
                        merged_next = 1'b0;
                        root_next   = '0;
                        size_next   = '0;
                    end
                    else
                    begin
                        error_next  = 1'b0;
                        req_next    = req_type;
                        cur_next    = node_a[AW-1:0];
                        node_b_next = node_b[AW-1:0];
                        phase_next  = 1'b0;
                    end
                end
            end
            ST_CHECK:
            begin
                // not a root: remember the parent and fetch the grandparent
                ptr_next      = rd_par;
                cur_size_next = rd_size;
                mem_raddr     = rd_par;
            end
            ST_HALVE:
            begin
                // point the node at its grandparent and step there
                mem_we    = 1'b1;
                mem_waddr = cur_reg;
                mem_wdata = {cur_size_reg, rd_par};
                cur_next  = rd_par;
                mem_raddr = rd_par;
            end
            ST_LINK:
            begin
                mem_we    = 1'b1;
                mem_waddr = small_root;
                mem_wdata = {small_size, big_root};
            end
            ST_GROW:
            begin
                mem_we           = 1'b1;
                mem_waddr        = big_root;
                mem_wdata        = {sum_size, big_root};
                merge_total_next = merge_total_reg + AW'(1);
                done_next        = 1'b1;
                merged_next      = 1'b1;
                root_next        = big_root;
                size_next        = sum_size;
            end
            default:
            begin
                clr_idx_next = '0;
            end
        endcase

        if (found)
        begin
            if (!last_walk)
            begin
                root_a_next = found_idx;
                size_a_next = rd_size;
                phase_next  = 1'b1;
                cur_next    = node_b_reg;
                mem_raddr   = node_b_reg;
            end
            else if (req_reg == REQ_FIND)
            begin
                done_next   = 1'b1;
                merged_next = 1'b0;
                root_next   = found_idx;
                size_next   = rd_size;
            end
            else
            begin
                root_b_next = found_idx;
                size_b_next = rd_size;
                if (same_root)
                begin
                    done_next   = 1'b1;
                    merged_next = 1'b0;
                    root_next   = root_a_reg;
                    size_next   = size_a_reg;
                end
            end
        end

        if (cfg_we)
        begin
            num_nodes_next   = cfg_wdata;
            merge_total_next = '0;
            clr_idx_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            num_nodes_reg   <= CNT_W'(MAX_NODES);
            merge_total_reg <= '0;
            clr_idx_reg     <= '0;
            phase_reg       <= 1'b0;
            req_reg         <= REQ_FIND;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            num_nodes_reg   <= num_nodes_next;
            merge_total_reg <= merge_total_next;
            clr_idx_reg     <= clr_idx_next;
            phase_reg       <= phase_next;
            req_reg         <= req_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_b_reg   <= node_b_next;
        cur_reg      <= cur_next;
        cur_size_reg <= cur_size_next;
        ptr_reg      <= ptr_next;
        root_a_reg   <= root_a_next;
        size_a_reg   <= size_a_next;
        root_b_reg   <= root_b_next;
        size_b_reg   <= size_b_next;
        merged_reg   <= merged_next;
        root_reg     <= root_next;
        size_reg     <= size_next;
        error_reg    <= error_next;
    end

    assign done            = done_reg;
    assign merged          = merged_reg;
    assign root_index      = IDX_W'(root_reg);
    assign root_set_size   = CNT_W'(size_reg);
    assign components_left = left;
    assign single_set      = (left == CNT_W'(1));
    assign index_error     = error_reg;

endmodule

`default_nettype wire

FILE: rtl/ufsm_checker.sv
`default_nettype none

module ufsm_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire logic                        done,
    input  wire logic                        merged,
    input  wire logic [ufsm_pkg::IDX_W-1:0]  root_index,
    input  wire logic [ufsm_pkg::CNT_W-1:0]  root_set_size,
    input  wire logic [ufsm_pkg::CNT_W-1:0]  components_left,
    input  wire logic                        single_set,
    input  wire logic                        index_error
);

    import ufsm_pkg::*;

    // a word is never shown while a request is still in flight
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // an accepted request either answers at once or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted request dropped");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && index_error) |-> (!merged && (root_index == '0) && (root_set_size == '0)))
        else $error("error word carries data");

    a_single_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (single_set == (components_left == CNT_W'(1))))
        else $error("single_set disagrees with components_left");

    // a merge joins two nonempty sets
    a_merge_size: assert property (@(posedge clk) disable iff (!rst_n)
        (done && merged) |-> (!index_error && (root_set_size >= CNT_W'(2))))
        else $error("merge reported with too small a set");

endmodule

bind union_find_set_merger_unit ufsm_checker u_ufsm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .merged          (merged),
    .root_index      (root_index),
    .root_set_size   (root_set_size),
    .components_left (components_left),
    .single_set      (single_set),
    .index_error     (index_error)
);

`default_nettype wire

FILE: tb/union_find_set_merger_unit_test.sv
`default_nettype none

module union_find_set_merger_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ufsm_pkg::*;

    localparam int unsigned STALL_LIMIT = 4000;

    typedef struct {
        logic             kind;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
    } request_t;

    typedef struct {
        logic             merged;
        logic [IDX_W-1:0] root;
        logic [CNT_W-1:0] size;
        logic [CNT_W-1:0] left;
        logic             single;
        logic             err;
    } answer_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    logic             start = 1'b0;
    logic             req_type = REQ_UNITE;
    logic [IDX_W-1:0] node_a = '0;
    logic [IDX_W-1:0] node_b = '0;
    logic             busy;
    logic             done;
    logic             merged;
    logic [IDX_W-1:0] root_index;
    logic [CNT_W-1:0] root_set_size;
    logic [CNT_W-1:0] components_left;
    logic             single_set;
    logic             index_error;

    union_find_set_merger_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .node_a          (node_a),
        .node_b          (node_b),
        .done            (done),
        .merged          (merged),
        .root_index      (root_index),
        .root_set_size   (root_set_size),
        .components_left (components_left),
        .single_set      (single_set),
        .index_error     (index_error)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // disjoint-set shadow of the block
    logic [IDX_W-1:0] dsu_parent [MAX_NODES];
    logic [CNT_W-1:0] dsu_size [MAX_NODES];
    logic [IDX_W-1:0] dsu_merges;
    logic [CNT_W-1:0] dsu_limit;

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    int       fault_count = 0;
    int       sent_count = 0;

    function automatic void reload_sets(input logic [CNT_W-1:0] value);
        dsu_limit = value;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            dsu_parent[i] = IDX_W'(i);
            dsu_size[i]   = CNT_W'(1);
        end
        dsu_merges = '0;
    endfunction

    function automatic int unsigned in_use();
        int unsigned n;
        n = dsu_limit;
        if (n < 1) n = 1;
        if (n > MAX_NODES) n = MAX_NODES;
        return n;
    endfunction

    // path halving: point each visited link at its grandparent
    function automatic logic [IDX_W-1:0] walk_to_root(input logic [IDX_W-1:0] x);
        int guard;
        guard = 0;
        while (dsu_parent[x] != x && guard < MAX_NODES)
        begin
            dsu_parent[x] = dsu_parent[dsu_parent[x]];
            x = dsu_parent[x];
            guard++;
        end
        return x;
    endfunction

    function automatic answer_t resolve_request(input request_t rq);
        answer_t          ans;
        logic [IDX_W-1:0] ra;
        logic [IDX_W-1:0] rb;
        logic [IDX_W-1:0] tmp;
        int unsigned      n;
        ans = '{default: '0};
        n = in_use();
        if (rq.a >= n || (rq.kind == REQ_UNITE && rq.b >= n))
        begin
            ans.err = 1'b1;
        end
        else if (rq.kind == REQ_FIND)
        begin
            ans.root = walk_to_root(rq.a);
            ans.size = dsu_size[ans.root];
        end
        else
        begin
            ra = walk_to_root(rq.a);
            rb = walk_to_root(rq.b);
            if (ra != rb)
            begin
                if (dsu_size[ra] < dsu_size[rb])
                begin
                    tmp = ra;
                    ra  = rb;
                    rb  = tmp;
                end
                dsu_parent[rb] = ra;
                dsu_size[ra]   = dsu_size[ra] + dsu_size[rb];
                dsu_merges     = dsu_merges + 1'b1;
                ans.merged     = 1'b1;
            end
            ans.root = ra;
            ans.size = dsu_size[ra];
        end
        ans.left   = (dsu_merges < n) ? CNT_W'(n - dsu_merges) : '0;
        ans.single = (ans.left == 1);
        return ans;
    endfunction

    // driver: hold a word until accepted, idle at random otherwise
    always @(posedge clk)
    begin : drive_words
        request_t nxt;
        logic     took;
        logic     steady;
        if (rst_n)
        begin
            took = start && !busy;
            if (took)
            begin
                nxt.kind = req_type;
                nxt.a    = node_a;
                nxt.b    = node_b;
                expected_answers.insert(expected_answers.size(), resolve_request(nxt));
                sent_count++;
            end
            steady = (sent_count >= 300 && sent_count < 420);
            if (!start || took)
            begin
                if (pending_requests.size() != 0 && (steady || $urandom_range(0, 99) >= 27))
                begin
                    nxt = pending_requests.pop_front();
                    start    <= 1'b1;
                    req_type <= nxt.kind;
                    node_a   <= nxt.a;
                    node_b   <= nxt.b;
                end
                else
                begin
                    start    <= 1'b0;
                    req_type <= 1'($urandom);
                    node_a   <= IDX_W'($urandom);
                    node_b   <= IDX_W'($urandom);
                end
            end
        end
    end

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fault_count++;
        end
    endtask

    // monitor: results cannot be held off, take each one as it comes
    always @(posedge clk)
    begin : watch_results
        answer_t want;
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual root %0d size %0d",
                         $time, root_index, root_set_size);
                fault_count++;
            end
            else
            begin
                want = expected_answers.pop_front();
                compare_field("merged", want.merged, merged);
                compare_field("root_index", want.root, root_index);
                compare_field("root_set_size", want.size, root_set_size);
                compare_field("components_left", want.left, components_left);
                compare_field("single_set", want.single, single_set);
                compare_field("index_error", want.err, index_error);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int stall_cycles;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
        else
        begin
            stall_cycles = 0;
        end
    end

    task automatic push_request(input logic kind, input int unsigned a, input int unsigned b);
        request_t rq;
        rq.kind = kind;
        rq.a    = IDX_W'(a);
        rq.b    = IDX_W'(b);
        pending_requests.insert(pending_requests.size(), rq);
    endtask

    task automatic push_random(input int count);
        int unsigned n;
        int unsigned a;
        int unsigned b;
        int unsigned roll;
        logic        kind;
        n = in_use();
        for (int k = 0; k < count; k++)
        begin
            kind = ($urandom_range(0, 99) < 30) ? REQ_FIND : REQ_UNITE;
            a    = $urandom_range(0, n - 1);
            b    = $urandom_range(0, n - 1);
            roll = $urandom_range(0, 99);
            // a few indices past the count in use
            if (n < MAX_NODES && roll < 8)
                a = $urandom_range(n, MAX_NODES - 1);
            else if (n < MAX_NODES && roll < 14)
                b = $urandom_range(n, MAX_NODES - 1);
            if (kind == REQ_FIND && roll >= 50)
                b = $urandom_range(0, MAX_NODES - 1);
            push_request(kind, a, b);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || start || expected_answers.size() != 0 || busy);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        reload_sets(value);
        @(negedge clk);
    endtask

    int phase_count [8] = '{2047, 16, 64, 8, 300, 1, 1024, 40};
    int phase_len   [8] = '{150, 70, 160, 40, 160, 10, 80, 80};

    initial
    begin
        reload_sets(CNT_W'(NODES_DEF));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // full count: edge indices, same-set unite, equal-size tie, smaller under larger
        push_request(REQ_UNITE, 0, 1023);
        push_request(REQ_UNITE, 1023, 0);
        push_request(REQ_FIND, 1023, 'h155);
        push_request(REQ_UNITE, 2, 3);
        push_request(REQ_UNITE, 4, 5);
        push_request(REQ_UNITE, 5, 2);
        push_request(REQ_UNITE, 1, 4);
        push_request(REQ_FIND, 3, 'h2AA);
        push_request(REQ_FIND, 'h2AA, 'h3FF);

        // two elements: bad indices on either side, find ignores node_b, down to one set
        write_count(CNT_W'(2));
        push_request(REQ_UNITE, 0, 1);
        push_request(REQ_FIND, 1, 0);
        push_request(REQ_UNITE, 2, 0);
        push_request(REQ_FIND, 1023, 0);
        push_request(REQ_UNITE, 0, 1023);
        push_request(REQ_FIND, 0, 1023);
        push_request(REQ_UNITE, 1, 0);

        // zero clamps up to one element
        write_count('0);
        push_request(REQ_FIND, 0, 0);
        push_request(REQ_UNITE, 0, 0);
        push_request(REQ_FIND, 1, 0);
        push_request(REQ_UNITE, 0, 1);

        for (int p = 0; p < 8; p++)
        begin
            write_count(CNT_W'(phase_count[p]));
            push_random(phase_len[p]);
        end

        wait_drained();
        repeat (60) @(posedge clk);
        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/ufsm_pkg.sv
rtl/ufsm_ram.sv
rtl/union_find_set_merger_unit.sv
rtl/ufsm_checker.sv
tb/union_find_set_merger_unit_test.sv
